// ===== sv/dual_pedal_sensor_drive_enable_core_defines.svh =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_PEDAL_SENSOR_DRIVE_ENABLE_CORE_DEFINES_SVH
`define DUAL_PEDAL_SENSOR_DRIVE_ENABLE_CORE_DEFINES_SVH

// General property on the checker clock and reset.
`define DPSDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that must hold whenever a result item is offered.
`define DPSDE_ASSERT_RES(lbl, cond, msg) \
    `DPSDE_ASSERT(lbl, i_res_valid |-> (cond), msg)

`endif

// ===== sv/dpsde_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: package
// Widths, constants, item types and register codes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpsde_pkg;

    localparam int POS_W     = 14;
    localparam int PCT_W     = 13;
    localparam int THR_W     = 8;
    localparam int TIMER_W   = 16;
    localparam int DT_W      = 8;
    localparam int LIMIT_W   = 7;
    localparam int MT_W      = 12;
    localparam int TORQUE_W  = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [PCT_W-1:0]   THR_CAP   = 13'd150;

    // Percent = floor(travel * 10 / 21) as a reciprocal multiply.
    localparam int               PCT_SHIFT = 24;
    localparam int               PCT_MUL_W = 23;
    localparam logic [22:0]      PCT_MUL   = 23'd7989160;

    // Torque = floor((throttle * max + 50) / 100) as a reciprocal multiply.
    localparam int               TQ_Y_W       = 20;
    localparam logic [TQ_Y_W-1:0] TQ_ROUND    = 20'd50;
    localparam int               DIV100_SHIFT = 27;
    localparam int               DIV100_W     = 21;
    localparam logic [20:0]      DIV100_MUL   = 21'd1342178;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_SCALE = 3'd4;

    localparam logic [LIMIT_W-1:0] RST_DEV_LIMIT    = 7'd10;
    localparam logic [TIMER_W-1:0] RST_DEV_TIME     = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_WATCHDOG     = 16'd2000;
    localparam logic [THR_W-1:0]   RST_ARM_MAX      = 8'd5;
    localparam logic [MT_W-1:0]    RST_TORQUE_SCALE = 12'd2150;

    typedef struct packed {
        logic [POS_W-1:0] raw_position_a;
        logic [POS_W-1:0] raw_position_b;
        logic             shutdown_closed;
        logic             dash_message;
        logic             dash_switch;
        logic [DT_W-1:0]  elapsed_ms;
    } t_sample;

    typedef struct packed {
        logic [THR_W-1:0]    throttle_pct;
        logic [TORQUE_W-1:0] torque_command;
        logic                drive_enable;
        logic                clear_faults;
        logic                deviation_fault;
        logic                switch_state;
        logic [POS_W-1:0]    travel_a;
        logic [POS_W-1:0]    travel_b;
    } t_result;

    typedef struct packed {
        logic            shutdown_closed;
        logic            dash_message;
        logic            dash_switch;
        logic [DT_W-1:0] elapsed_ms;
    } t_ctl;

    typedef struct packed {
        logic [LIMIT_W-1:0] deviation_limit_pct;
        logic [TIMER_W-1:0] deviation_time_ms;
        logic [TIMER_W-1:0] watchdog_ms;
        logic [THR_W-1:0]   arm_throttle_max;
        logic [MT_W-1:0]    torque_scale;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/dpsde_if.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dpsde_sample_if;
    logic               valid;
    logic               ready;
    dpsde_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpsde_result_if;
    logic               valid;
    logic               ready;
    dpsde_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpsde_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dpsde_pkg::CFG_IDX_W-1:0]     index;
    logic [dpsde_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/dpsde_lane.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: sensor lane
// Tracks the lowest reading as auto-zero, forms travel and its percent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpsde_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_load,
    input  wire logic [dpsde_pkg::POS_W-1:0] i_pos,
    output logic      [dpsde_pkg::POS_W-1:0] o_travel,
    output logic      [dpsde_pkg::PCT_W-1:0] o_pct
);

    localparam int PROD_W = dpsde_pkg::POS_W + dpsde_pkg::PCT_MUL_W;

    logic [dpsde_pkg::POS_W-1:0] r_floor;
    logic [dpsde_pkg::POS_W-1:0] n_floor;
    logic [dpsde_pkg::POS_W-1:0] w_travel;
    logic [dpsde_pkg::POS_W-1:0] r_travel1;
    logic [dpsde_pkg::POS_W-1:0] r_travel2;
    logic [dpsde_pkg::PCT_W-1:0] r_pct;
    logic [PROD_W-1:0]           w_prod;

    always_comb begin
        n_floor  = (i_pos < r_floor) ? i_pos : r_floor;
        w_travel = i_pos - n_floor;
        w_prod   = PROD_W'(r_travel1) * PROD_W'(dpsde_pkg::PCT_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= dpsde_pkg::POS_MAX;
        end else if (i_load) begin
            r_floor <= n_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_travel1 <= w_travel;
            r_travel2 <= r_travel1;
            r_pct     <= w_prod[dpsde_pkg::PCT_SHIFT +: dpsde_pkg::PCT_W];
        end
    end

    assign o_travel = r_travel2;
    assign o_pct    = r_pct;

endmodule

`default_nettype wire

// ===== sv/dpsde_merge.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: lane merge
// Combines both percents into throttle, runs the disagreement and watchdog
// timers and the drive enable state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpsde_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [dpsde_pkg::PCT_W-1:0] i_pct_a,
    input  wire logic [dpsde_pkg::PCT_W-1:0] i_pct_b,
    input  wire logic [dpsde_pkg::POS_W-1:0] i_travel_a,
    input  wire logic [dpsde_pkg::POS_W-1:0] i_travel_b,
    input  wire dpsde_pkg::t_ctl             i_ctl,
    input  wire dpsde_pkg::t_cfg             i_cfg,
    output logic                             o_valid,
    output dpsde_pkg::t_result               o_res
);

    function automatic logic [dpsde_pkg::TIMER_W-1:0] sat_add(
        input logic [dpsde_pkg::TIMER_W-1:0] t,
        input logic [dpsde_pkg::DT_W-1:0]    d
    );
        logic [dpsde_pkg::TIMER_W:0] s;
        s = {1'b0, t} + (dpsde_pkg::TIMER_W + 1)'(d);
        return s[dpsde_pkg::TIMER_W] ? dpsde_pkg::TIMER_MAX : s[dpsde_pkg::TIMER_W-1:0];
    endfunction

    logic [dpsde_pkg::PCT_W-1:0]   w_min;
    logic [dpsde_pkg::PCT_W-1:0]   w_gap;
    logic [dpsde_pkg::THR_W-1:0]   w_thr;
    logic                          w_over;

    logic                          r_v3;
    logic [dpsde_pkg::THR_W-1:0]   r_thr3;
    logic                          r_over3;
    dpsde_pkg::t_ctl               r_ctl3;
    logic [dpsde_pkg::POS_W-1:0]   r_ta3;
    logic [dpsde_pkg::POS_W-1:0]   r_tb3;

    logic [dpsde_pkg::TIMER_W-1:0] r_silence, n_silence;
    logic                          r_switch, n_switch;
    logic [dpsde_pkg::TIMER_W-1:0] r_dtime, n_dtime;
    logic                          r_active, n_active;
    logic                          r_fault, n_fault;
    logic                          r_drive, n_drive;
    logic                          w_arm;
    logic                          w_step;

    logic                          r_v4;
    dpsde_pkg::t_result            r_res4;

    always_comb begin
        w_min  = (i_pct_a < i_pct_b) ? i_pct_a : i_pct_b;
        w_thr  = (w_min > dpsde_pkg::THR_CAP) ? '0 : w_min[dpsde_pkg::THR_W-1:0];
        w_gap  = (i_pct_a > i_pct_b) ? (i_pct_a - i_pct_b) : (i_pct_b - i_pct_a);
        w_over = w_gap > dpsde_pkg::PCT_W'(i_cfg.deviation_limit_pct);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_thr3  <= w_thr;
            r_over3 <= w_over;
            r_ctl3  <= i_ctl;
            r_ta3   <= i_travel_a;
            r_tb3   <= i_travel_b;
        end
    end

    assign w_step = i_en && r_v3;

    always_comb begin
        if (r_ctl3.dash_message) begin
            n_silence = '0;
            n_switch  = r_ctl3.dash_switch;
        end else begin
            n_silence = sat_add(r_silence, r_ctl3.elapsed_ms);
            n_switch  = r_switch;
        end
        if (n_silence > i_cfg.watchdog_ms) begin
            n_switch = 1'b0;
        end

        n_fault = r_fault;
        if (r_over3) begin
            n_active = 1'b1;
            n_dtime  = r_active ? sat_add(r_dtime, r_ctl3.elapsed_ms) : '0;
            if (n_dtime > i_cfg.deviation_time_ms) begin
                n_fault = 1'b1;
            end
        end else begin
            n_active = 1'b0;
            n_dtime  = '0;
        end

        w_arm   = !r_drive && (r_thr3 < i_cfg.arm_throttle_max) &&
                  r_ctl3.shutdown_closed && n_switch;
        n_drive = (r_drive || w_arm) && r_ctl3.shutdown_closed && n_switch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= '0;
            r_switch  <= 1'b0;
            r_dtime   <= '0;
            r_active  <= 1'b0;
            r_fault   <= 1'b0;
            r_drive   <= 1'b0;
        end else if (w_step) begin
            r_silence <= n_silence;
            r_switch  <= n_switch;
            r_dtime   <= n_dtime;
            r_active  <= n_active;
            r_fault   <= n_fault;
            r_drive   <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res4.throttle_pct    <= r_thr3;
            r_res4.torque_command  <= '0;
            r_res4.drive_enable    <= n_drive;
            r_res4.clear_faults    <= w_arm;
            r_res4.deviation_fault <= n_fault;
            r_res4.switch_state    <= n_switch;
            r_res4.travel_a        <= r_ta3;
            r_res4.travel_b        <= r_tb3;
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r_res4;

endmodule

`default_nettype wire

// ===== sv/dpsde_torque.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: torque scaler
// Scales throttle by the maximum torque and divides by one hundred with
// rounding, holding the finished result item in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpsde_torque (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire dpsde_pkg::t_result         i_res,
    input  wire logic [dpsde_pkg::MT_W-1:0] i_torque_scale,
    output logic                            o_valid,
    output dpsde_pkg::t_result              o_res
);

    localparam int Y_W = dpsde_pkg::TQ_Y_W;
    localparam int Q_W = Y_W + dpsde_pkg::DIV100_W;

    logic [dpsde_pkg::THR_W-1:0] w_thr;
    logic [Y_W-1:0]              w_y;
    logic [Q_W-1:0]              w_q;
    dpsde_pkg::t_result          w_res6;
    logic                        r_v5;
    logic                        r_v6;
    logic [Y_W-1:0]              r_y5;
    dpsde_pkg::t_result          r_res5;
    dpsde_pkg::t_result          r_res6;

    always_comb begin
        w_thr  = i_res.drive_enable ? i_res.throttle_pct : '0;
        w_y    = Y_W'(w_thr) * Y_W'(i_torque_scale) + dpsde_pkg::TQ_ROUND;
        w_q    = Q_W'(r_y5) * Q_W'(dpsde_pkg::DIV100_MUL);
        w_res6 = r_res5;
        w_res6.torque_command = w_q[dpsde_pkg::DIV100_SHIFT +: dpsde_pkg::TORQUE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y5   <= w_y;
            r_res5 <= i_res;
            r_res6 <= w_res6;
        end
    end

    assign o_valid = r_v6;
    assign o_res   = r_res6;

endmodule

`default_nettype wire

// ===== sv/dual_pedal_sensor_drive_enable_core.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: top level
// Pedal position plausibility check with auto-zero, sticky deviation fault,
// dashboard watchdog, drive enable arming and torque command.
//
//   Channel   Dir   Payload               Handshake
//   i_smp     in    t_sample (sample)     valid/ready
//   o_res     out   t_result (result)     valid/ready
//   i_cfg     in    index 3b, data 16b    valid/ready, ready always high
//
// One item is accepted per cycle while the result channel is not stalled;
// each result passes the six-stage pipeline (two sensor lanes, merge, torque scaler).
// Reset restores the tracked zeros, timers, fault, drive state and registers.
// A low ready on the result channel while a result is offered freezes the
// whole pipeline and drops the sample ready in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_pedal_sensor_drive_enable_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    dpsde_sample_if.sink    i_smp,
    dpsde_result_if.source  o_res,
    dpsde_cfg_if.sink       i_cfg
);

    logic                        w_en;
    logic                        w_load;
    logic                        r_v1;
    logic                        r_v2;
    dpsde_pkg::t_ctl             w_ctl0;
    dpsde_pkg::t_ctl             r_ctl1;
    dpsde_pkg::t_ctl             r_ctl2;
    dpsde_pkg::t_cfg             r_cfg;
    logic [dpsde_pkg::POS_W-1:0] w_pos_b_inv;
    logic [dpsde_pkg::POS_W-1:0] w_travel_a;
    logic [dpsde_pkg::POS_W-1:0] w_travel_b;
    logic [dpsde_pkg::PCT_W-1:0] w_pct_a;
    logic [dpsde_pkg::PCT_W-1:0] w_pct_b;
    logic                        w_merge_valid;
    dpsde_pkg::t_result          w_merge_res;
    logic                        w_out_valid;
    dpsde_pkg::t_result          w_out_res;

    assign w_en        = !w_out_valid || o_res.ready;
    assign w_load      = i_smp.valid && w_en;
    assign i_smp.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // Sensor B falls with travel, so its complement tracks like sensor A.
    assign w_pos_b_inv = ~i_smp.data.raw_position_b;

    always_comb begin
        w_ctl0.shutdown_closed = i_smp.data.shutdown_closed;
        w_ctl0.dash_message    = i_smp.data.dash_message;
        w_ctl0.dash_switch     = i_smp.data.dash_switch;
        w_ctl0.elapsed_ms      = i_smp.data.elapsed_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deviation_limit_pct <= dpsde_pkg::RST_DEV_LIMIT;
            r_cfg.deviation_time_ms   <= dpsde_pkg::RST_DEV_TIME;
            r_cfg.watchdog_ms         <= dpsde_pkg::RST_WATCHDOG;
            r_cfg.arm_throttle_max    <= dpsde_pkg::RST_ARM_MAX;
            r_cfg.torque_scale        <= dpsde_pkg::RST_TORQUE_SCALE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dpsde_pkg::CFG_DEV_LIMIT: begin
                    r_cfg.deviation_limit_pct <= i_cfg.data[dpsde_pkg::LIMIT_W-1:0];
                end
                dpsde_pkg::CFG_DEV_TIME: begin
                    r_cfg.deviation_time_ms <= i_cfg.data[dpsde_pkg::TIMER_W-1:0];
                end
                dpsde_pkg::CFG_WATCHDOG: begin
                    r_cfg.watchdog_ms <= i_cfg.data[dpsde_pkg::TIMER_W-1:0];
                end
                dpsde_pkg::CFG_ARM_MAX: begin
                    r_cfg.arm_throttle_max <= i_cfg.data[dpsde_pkg::THR_W-1:0];
                end
                dpsde_pkg::CFG_TORQUE_SCALE: begin
                    r_cfg.torque_scale <= i_cfg.data[dpsde_pkg::MT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_smp.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl1 <= w_ctl0;
            r_ctl2 <= r_ctl1;
        end
    end

    dpsde_lane u_lane_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_load   (w_load),
        .i_pos    (i_smp.data.raw_position_a),
        .o_travel (w_travel_a),
        .o_pct    (w_pct_a)
    );

    dpsde_lane u_lane_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_load   (w_load),
        .i_pos    (w_pos_b_inv),
        .o_travel (w_travel_b),
        .o_pct    (w_pct_b)
    );

    dpsde_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v2),
        .i_pct_a    (w_pct_a),
        .i_pct_b    (w_pct_b),
        .i_travel_a (w_travel_a),
        .i_travel_b (w_travel_b),
        .i_ctl      (r_ctl2),
        .i_cfg      (r_cfg),
        .o_valid    (w_merge_valid),
        .o_res      (w_merge_res)
    );

    dpsde_torque u_torque (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_merge_valid),
        .i_res          (w_merge_res),
        .i_torque_scale (r_cfg.torque_scale),
        .o_valid        (w_out_valid),
        .o_res          (w_out_res)
    );

    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_out_res;

endmodule

`default_nettype wire

// ===== sv/dpsde_checker.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: port checker
// Watches the result channel for handshake and consistency rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_pedal_sensor_drive_enable_core_defines.svh"

module dpsde_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire dpsde_pkg::t_result i_res_data
);

    `DPSDE_ASSERT(a_res_hold, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data), "stalled result item changed")
    `DPSDE_ASSERT_RES(a_clear_needs_drive, !i_res_data.clear_faults || i_res_data.drive_enable, "clear_faults without drive_enable")
    `DPSDE_ASSERT_RES(a_torque_needs_drive, i_res_data.drive_enable || (i_res_data.torque_command == '0), "torque while drive is off")
    `DPSDE_ASSERT_RES(a_throttle_cap, i_res_data.throttle_pct <= 8'd150, "throttle above 150 percent")

endmodule

bind dual_pedal_sensor_drive_enable_core dpsde_checker u_dpsde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Pedal sensor drive enable: testbench
// Sends pedal samples and register writes over the valid/ready channels, with
// random idle cycles on both sides. Each result item is checked, field by
// field, against an in-bench predictor of the auto-zero, plausibility,
// deviation fault, dashboard watchdog, arming and torque logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import dpsde_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int          MAX_REPORTS = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    dpsde_sample_if smp_ch ();
    dpsde_result_if res_ch ();
    dpsde_cfg_if    cfg_ch ();

    dual_pedal_sensor_drive_enable_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    t_cfg            active_cfg;
    logic [POS_W-1:0] zero_a;
    logic [POS_W-1:0] peak_b;
    logic             mismatch_on;
    logic [15:0]      mismatch_ms;
    logic             mismatch_fault;
    logic [15:0]      quiet_ms;
    logic             switch_on;
    logic             drive_armed;

    t_result     expected_results[$];
    int          error_count = 0;
    bit          steady = 1'b0;
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [15:0] timer_add(input logic [15:0] t, input logic [7:0] d);
        logic [16:0] sum;
        sum = {1'b0, t} + {9'd0, d};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic t_result predict_result(input t_sample s);
        t_result     r;
        int unsigned ta;
        int unsigned tb;
        int unsigned pa;
        int unsigned pb;
        int unsigned thr;
        int unsigned spread;
        logic        clr;
        r = '0;
        clr = 1'b0;
        if (s.dash_message) begin
            quiet_ms = '0;
            switch_on = s.dash_switch;
        end else begin
            quiet_ms = timer_add(quiet_ms, s.elapsed_ms);
        end
        if (s.raw_position_a < zero_a) zero_a = s.raw_position_a;
        if (s.raw_position_b > peak_b) peak_b = s.raw_position_b;
        ta = s.raw_position_a - zero_a;
        tb = peak_b - s.raw_position_b;
        pa = ta * 10 / 21;
        pb = tb * 10 / 21;
        thr = (pa < pb) ? pa : pb;
        if (thr > 150) thr = 0;
        spread = (pa > pb) ? pa - pb : pb - pa;
        if (spread > active_cfg.deviation_limit_pct) begin
            if (mismatch_on) begin
                mismatch_ms = timer_add(mismatch_ms, s.elapsed_ms);
            end else begin
                mismatch_on = 1'b1;
                mismatch_ms = '0;
            end
            if (mismatch_ms > active_cfg.deviation_time_ms) mismatch_fault = 1'b1;
        end else begin
            mismatch_on = 1'b0;
            mismatch_ms = '0;
        end
        if (quiet_ms > active_cfg.watchdog_ms) switch_on = 1'b0;
        if (!drive_armed && thr < active_cfg.arm_throttle_max && s.shutdown_closed
                && switch_on) begin
            clr = 1'b1;
            drive_armed = 1'b1;
        end
        if (!s.shutdown_closed || !switch_on) drive_armed = 1'b0;
        r.throttle_pct    = thr[THR_W-1:0];
        r.torque_command  = drive_armed ? TORQUE_W'((thr * active_cfg.torque_scale + 50) / 100)
                                        : '0;
        r.drive_enable    = drive_armed;
        r.clear_faults    = clr;
        r.deviation_fault = mismatch_fault;
        r.switch_state    = switch_on;
        r.travel_a        = ta[POS_W-1:0];
        r.travel_b        = tb[POS_W-1:0];
        return r;
    endfunction

    function automatic t_sample build_sample(input int a, input int b, input bit shut,
                                             input bit msg, input bit sw, input int dt);
        t_sample s;
        s.raw_position_a  = a[POS_W-1:0];
        s.raw_position_b  = b[POS_W-1:0];
        s.shutdown_closed = shut;
        s.dash_message    = msg;
        s.dash_switch     = sw;
        s.elapsed_ms      = dt[DT_W-1:0];
        return s;
    endfunction

    // Mostly plausible pedal strokes relative to the current auto-zero points,
    // with occasional wide disagreement and fully random angles as noise.
    function automatic t_sample random_sample(input int noise_pct, input int msg_pct);
        int a;
        int b;
        int travel_a;
        int travel_b;
        int offset;
        if ($urandom_range(0, 99) < noise_pct) begin
            a = $urandom_range(0, 16383);
            b = $urandom_range(0, 16383);
        end else begin
            travel_a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(0, 340);
            if ($urandom_range(0, 4) == 0) begin
                offset = $urandom_range(0, 120);
                travel_b = travel_a + offset - 60;
            end else begin
                offset = $urandom_range(0, 16);
                travel_b = travel_a + offset - 8;
            end
            if (travel_b < 0) travel_b = 0;
            a = int'(zero_a) + travel_a;
            if (a > 16383) a = 16383;
            b = int'(peak_b) - travel_b;
            if (b < 0) b = 0;
        end
        return build_sample(a, b, $urandom_range(0, 9) != 0, $urandom_range(0, 99) < msg_pct,
                            $urandom_range(0, 6) != 0,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 40));
    endfunction

    task automatic send_sample(input t_sample s);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            smp_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_ch.data  = s;
        smp_ch.valid = 1'b1;
        do @(posedge i_clk); while (smp_ch.ready !== 1'b1);
        expected_results.push_back(predict_result(s));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        smp_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_DEV_LIMIT:    active_cfg.deviation_limit_pct = value[LIMIT_W-1:0];
            CFG_DEV_TIME:     active_cfg.deviation_time_ms   = value;
            CFG_WATCHDOG:     active_cfg.watchdog_ms         = value;
            CFG_ARM_MAX:      active_cfg.arm_throttle_max    = value[THR_W-1:0];
            CFG_TORQUE_SCALE: active_cfg.torque_scale        = value[MT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all_registers(input t_cfg c);
        write_register(CFG_DEV_LIMIT, {9'd0, c.deviation_limit_pct});
        write_register(CFG_DEV_TIME, c.deviation_time_ms);
        write_register(CFG_WATCHDOG, c.watchdog_ms);
        write_register(CFG_ARM_MAX, {8'd0, c.arm_throttle_max});
        write_register(CFG_TORQUE_SCALE, {4'd0, c.torque_scale});
    endtask

    task automatic run_random(input int count, input int noise_pct, input int msg_pct);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            send_sample(random_sample(noise_pct, msg_pct));
        end
        steady = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: result item with no sample pending, expected none, got %p",
                         $time, got);
            return;
        end
        want = expected_results.pop_front();
        check_field("throttle_pct", want.throttle_pct, got.throttle_pct);
        check_field("torque_command", want.torque_command, got.torque_command);
        check_field("drive_enable", want.drive_enable, got.drive_enable);
        check_field("clear_faults", want.clear_faults, got.clear_faults);
        check_field("deviation_fault", want.deviation_fault, got.deviation_fault);
        check_field("switch_state", want.switch_state, got.switch_state);
        check_field("travel_a", want.travel_a, got.travel_a);
        check_field("travel_b", want.travel_b, got.travel_b);
    endtask

    initial begin : result_monitor
        int stall;
        res_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            check_result(res_ch.data);
            @(negedge i_clk);
        end
    end

    // Arming, throttle limits, auto-zero extremes, shutdown, switch and watchdog
    // under the register values after reset.
    task automatic test_pedal_basics();
        send_sample(build_sample(16383, 0, 1, 1, 1, 0));
        send_sample(build_sample(1000, 15000, 1, 1, 1, 10));
        send_sample(build_sample(1210, 14790, 1, 1, 1, 10));
        send_sample(build_sample(1315, 14685, 1, 1, 1, 10));
        send_sample(build_sample(1317, 14683, 1, 1, 1, 10));
        send_sample(build_sample(1318, 14682, 1, 1, 1, 10));
        send_sample(build_sample(1105, 14895, 1, 1, 1, 10));
        send_sample(build_sample(16383, 0, 1, 1, 1, 10));
        send_sample(build_sample(1000, 15000, 1, 1, 1, 10));
        send_sample(build_sample(1010, 14990, 0, 1, 1, 20));
        send_sample(build_sample(1021, 14979, 1, 1, 1, 5));
        send_sample(build_sample(1008, 14992, 1, 1, 1, 5));
        send_sample(build_sample(1000, 15000, 1, 1, 0, 5));
        send_sample(build_sample(1000, 15000, 1, 1, 1, 5));
        for (int i = 0; i < 8; i++)
            send_sample(build_sample(1004, 14996, 1, 0, 1, 255));
        send_sample(build_sample(0, 16383, 1, 1, 1, 0));
    endtask

    // Both timers run into saturation with their limits at full scale, so
    // neither the fault nor the watchdog may fire.
    task automatic test_timer_saturation();
        wait_idle();
        write_register(CFG_DEV_TIME, 16'hFFFF);
        write_register(CFG_WATCHDOG, 16'hFFFF);
        for (int i = 0; i < 280; i++) begin
            if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            send_sample(build_sample(int'(zero_a) + $urandom_range(150, 300),
                                     int'(peak_b) - $urandom_range(0, 20), 1, 0,
                                     $urandom_range(0, 1),
                                     (i < 270) ? 255 : $urandom_range(200, 255)));
        end
        steady = 1'b0;
    endtask

    task automatic test_register_settings();
        t_cfg settings[5];
        settings[0] = '{deviation_limit_pct: 7'd0,   deviation_time_ms: 16'hFFFF,
                        watchdog_ms: 16'd0,          arm_throttle_max: 8'd0,
                        torque_scale: 12'd0};
        settings[1] = '{deviation_limit_pct: 7'd127, deviation_time_ms: 16'hFFFF,
                        watchdog_ms: 16'd300,        arm_throttle_max: 8'd255,
                        torque_scale: 12'd4095};
        settings[2] = '{deviation_limit_pct: 7'd100, deviation_time_ms: 16'hFFFE,
                        watchdog_ms: 16'hFFFE,       arm_throttle_max: 8'd150,
                        torque_scale: 12'd4095};
        settings[3] = '{deviation_limit_pct: LIMIT_W'($urandom_range(0, 127)),
                        deviation_time_ms: 16'($urandom_range(2000, 65535)),
                        watchdog_ms: 16'($urandom_range(100, 5000)),
                        arm_throttle_max: 8'($urandom_range(0, 255)),
                        torque_scale: 12'($urandom_range(0, 4095))};
        settings[4] = '{deviation_limit_pct: RST_DEV_LIMIT, deviation_time_ms: RST_DEV_TIME,
                        watchdog_ms: RST_WATCHDOG, arm_throttle_max: RST_ARM_MAX,
                        torque_scale: RST_TORQUE_SCALE};
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_all_registers(settings[p]);
            run_random(170, 15, 20 + 15 * p);
        end
    endtask

    // Disagreement that clears before the limit, then one that lasts long
    // enough to set the sticky fault; then the tightest possible settings.
    task automatic test_deviation_fault();
        wait_idle();
        write_register(CFG_DEV_LIMIT, 16'd10);
        write_register(CFG_DEV_TIME, 16'd500);
        send_sample(build_sample(int'(zero_a), int'(peak_b), 1, 1, 1, 50));
        for (int i = 0; i < 4; i++)
            send_sample(build_sample(int'(zero_a) + 210, int'(peak_b), 1, 1, 1, 100));
        send_sample(build_sample(int'(zero_a), int'(peak_b), 1, 1, 1, 100));
        for (int i = 0; i < 8; i++)
            send_sample(build_sample(int'(zero_a) + 210, int'(peak_b), 1, 1, 1, 100));
        wait_idle();
        write_register(CFG_DEV_LIMIT, 16'd0);
        write_register(CFG_DEV_TIME, 16'd0);
        run_random(100, 10, 50);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        smp_ch.valid = 1'b0;
        smp_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        active_cfg   = '{deviation_limit_pct: RST_DEV_LIMIT, deviation_time_ms: RST_DEV_TIME,
                         watchdog_ms: RST_WATCHDOG, arm_throttle_max: RST_ARM_MAX,
                         torque_scale: RST_TORQUE_SCALE};
        zero_a         = POS_MAX;
        peak_b         = '0;
        mismatch_on    = 1'b0;
        mismatch_ms    = '0;
        mismatch_fault = 1'b0;
        quiet_ms       = '0;
        switch_on      = 1'b0;
        drive_armed    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_pedal_basics();
        test_timer_saturation();
        test_register_settings();
        test_deviation_fault();

        wait_idle();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
